// ===== rtl/core/prr_pkg.sv =====
// shared types, constants and match functions for the pass rule table
package prr_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int PROTO_W = 8;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int STAT_W  = 2;
  localparam int RCNT_W  = 7;

  // stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = 1 + PROTO_W + 4 * ADDR_W + 3 * PORT_W + PROTO_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + STAT_W + RCNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  // add status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // protocols that carry ports
  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  // one stored rule
  typedef struct packed {
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  host;
    logic [ADDR_W-1:0]  mask;
    logic [PORT_W-1:0]  port;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // request from the stream side to the engine
  typedef struct packed {
    logic               op;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    rule_t              rule;
  } req_t;

  // response from the engine
  typedef struct packed {
    logic              matched;
    logic [STAT_W-1:0] status;
    logic [RCNT_W-1:0] count;
  } res_t;

  // packet against one rule: protocol, host and port tests
  function automatic logic rule_passes(rule_t r, logic [PROTO_W-1:0] proto,
                                       logic [ADDR_W-1:0] addr,
                                       logic [PORT_W-1:0] port);
    logic proto_ok;
    logic host_ok;
    logic port_ok;
    proto_ok = (r.proto == '0) || (r.proto == proto);
    host_ok  = (r.host == '0) || (r.host == (addr & r.mask));
    port_ok  = (r.port == '0) ||
               (((proto == PROTO_TCP) || (proto == PROTO_UDP)) && (port == r.port));
    return proto_ok && host_ok && port_ok;
  endfunction

  // identical rule test for duplicate detection
  function automatic logic rule_same(rule_t a, rule_t b);
    return (a.proto == b.proto) && (a.host == b.host) &&
           (a.mask == b.mask) && (a.port == b.port);
  endfunction

endpackage

// ===== rtl/core/packet_pass_rule_table.sv =====
// top level of the pass rule table: stream ports, rule memory, engine, output register
//
//  channel | direction | fields
//  in_     | slave     | tuser: operation; tdata: use_destination, ip_protocol, source_addr,
//          |           |   dest_addr, source_port, dest_port, rule_protocol, rule_host,
//          |           |   rule_mask, rule_port
//  out_    | master    | tdata: matched, add_status, rule_count
//
// an item is accepted, the held rules are read in turn and each compared after its registered
// read, then the item finishes; a hit ends the walk early, a full add skips it.
// the walk is bound by the single read port of the rule memory.
// reset clears the rule count; memory contents are left as they are.
// the output register frees the engine while a result waits on out_tready.
module packet_pass_rule_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] use_destination, [8:1] ip_protocol, [40:9] source_addr, [72:41] dest_addr,
  // [88:73] source_port, [104:89] dest_port, [112:105] rule_protocol,
  // [144:113] rule_host, [176:145] rule_mask, [192:177] rule_port
  input  logic [prr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] matched, [2:1] add_status, [9:3] rule_count
  output logic [prr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  prr_pkg::req_t             req;
  prr_pkg::res_t             res;
  logic                      res_valid;
  logic                      res_ready;
  logic                      ram_we;
  logic                      ram_re;
  logic [prr_pkg::IDX_W-1:0] ram_waddr;
  logic [prr_pkg::IDX_W-1:0] ram_raddr;
  prr_pkg::rule_t            ram_wdata;
  prr_pkg::rule_t            ram_rdata;

  logic                      use_dst;
  logic                      out_vld_r, out_vld_nxt;
  prr_pkg::res_t             out_res_r, out_res_nxt;

  // unpack the request and pick the direction
  assign use_dst         = in_tdata[0];
  assign req.op          = in_tuser;
  assign req.proto       = in_tdata[8:1];
  assign req.addr        = use_dst ? in_tdata[72:41] : in_tdata[40:9];
  assign req.port        = use_dst ? in_tdata[104:89] : in_tdata[88:73];
  assign req.rule.proto  = in_tdata[112:105];
  assign req.rule.host   = in_tdata[144:113];
  assign req.rule.mask   = in_tdata[176:145];
  assign req.rule.port   = in_tdata[192:177];

  // rule memory
  prr_ram #(
    .WIDTH (prr_pkg::RULE_W),
    .DEPTH (prr_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // table walk
  prr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register
  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(prr_pkg::OUT_TDATA_W - prr_pkg::OUT_FIELDS_W)'(0),
                       out_res_r.count, out_res_r.status, out_res_r.matched};

endmodule

// ===== rtl/core/prr_ram.sv =====
// generic single-port-write, registered-read memory
module prr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/prr_engine.sv =====
// table walk sequencer: scans stored rules for a match or a duplicate
module prr_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  prr_pkg::req_t             req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output prr_pkg::res_t             res,
  output logic                      ram_we,
  output logic [prr_pkg::IDX_W-1:0] ram_waddr,
  output prr_pkg::rule_t            ram_wdata,
  output logic                      ram_re,
  output logic [prr_pkg::IDX_W-1:0] ram_raddr,
  input  prr_pkg::rule_t            ram_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [prr_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [prr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      pend_r, pend_nxt;
  logic                      hit_r, hit_nxt;
  logic                      full_r, full_nxt;
  prr_pkg::req_t             req_r, req_nxt;

  logic                      hit_now;
  logic                      add_ok;
  logic [prr_pkg::CNT_W-1:0] count_inc;

  // compare the rule read last cycle against the held request
  always_comb begin
    if (req_r.op == prr_pkg::OP_CHECK) begin
      hit_now = prr_pkg::rule_passes(ram_rdata, req_r.proto, req_r.addr, req_r.port);
    end else begin
      hit_now = prr_pkg::rule_same(ram_rdata, req_r.rule);
    end
  end

  assign add_ok    = (req_r.op == prr_pkg::OP_ADD) && !full_r && !hit_r;
  assign count_inc = count_r + prr_pkg::CNT_W'(1);

  // table writes only happen at the end of an add, never during a scan
  assign ram_waddr = count_r[prr_pkg::IDX_W-1:0];
  assign ram_wdata = req_r.rule;
  assign ram_raddr = idx_r[prr_pkg::IDX_W-1:0];

  // response fields
  always_comb begin
    res.matched = (req_r.op == prr_pkg::OP_CHECK) && hit_r;
    if (req_r.op == prr_pkg::OP_CHECK) begin
      res.status = prr_pkg::ST_OK;
    end else if (full_r) begin
      res.status = prr_pkg::ST_FULL;
    end else if (hit_r) begin
      res.status = prr_pkg::ST_DUP;
    end else begin
      res.status = prr_pkg::ST_OK;
    end
    res.count = prr_pkg::RCNT_W'(add_ok ? count_inc : count_r);
  end

  // sequencer: accept, walk one entry per cycle, finish
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    full_nxt  = full_r;
    req_nxt   = req_r;
    req_ready = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt  = req;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          full_nxt = (req.op == prr_pkg::OP_ADD) &&
                     (count_r >= prr_pkg::CNT_W'(prr_pkg::TABLE_DEPTH));
          state_nxt = full_nxt ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r && hit_now) begin
          hit_nxt   = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else if (idx_r < count_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + prr_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (add_ok) begin
            ram_we    = 1'b1;
            count_nxt = count_inc;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      full_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      full_r  <= full_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // held request payload
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

endmodule

// ===== rtl/core/prr_checker.sv =====
// port-level checks for the pass rule table, bound to the top level
module prr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [prr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a duplicate or full report never carries a match, and no unused status code appears
  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:1] == prr_pkg::ST_OK ||
                    (out_tdata[2:1] != 2'd3 && !out_tdata[0])))
    else $error("bad status or match on add");

  // a full report means the table holds every entry
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:1] == prr_pkg::ST_FULL |->
      out_tdata[9:3] == prr_pkg::RCNT_W'(prr_pkg::TABLE_DEPTH))
    else $error("full reported below capacity");

endmodule

bind packet_pass_rule_table prr_checker u_prr_checker (.*);

// ===== dv/packet_pass_rule_table_tb.sv =====
// testbench for the pass rule table: directed and random add and check requests
module packet_pass_rule_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 4000;
  localparam int RANDOM_REQUESTS = 1230;
  localparam int POOL_SIZE       = 96;

  // one request as the stream carries it, operation included
  typedef struct packed {
    logic                        op;
    logic                        use_dst;
    logic [prr_pkg::PROTO_W-1:0] proto;
    logic [prr_pkg::ADDR_W-1:0]  saddr;
    logic [prr_pkg::ADDR_W-1:0]  daddr;
    logic [prr_pkg::PORT_W-1:0]  sport;
    logic [prr_pkg::PORT_W-1:0]  dport;
    prr_pkg::rule_t              rule;
  } request_t;

  // rule table shadow and the verdicts it predicts
  class rule_table_tracker;
    prr_pkg::rule_t held_rules[$];
    prr_pkg::res_t  verdict_q[$];
    int             mismatches;

    function new();
      mismatches = 0;
    endfunction

    // packet against one held rule
    function bit rule_admits(prr_pkg::rule_t r,
                             logic [prr_pkg::PROTO_W-1:0] proto,
                             logic [prr_pkg::ADDR_W-1:0] addr,
                             logic [prr_pkg::PORT_W-1:0] port);
      bit carries_ports;
      carries_ports = (proto == prr_pkg::PROTO_TCP) || (proto == prr_pkg::PROTO_UDP);
      if (r.proto != '0 && r.proto != proto) return 1'b0;
      if (r.host != '0 && r.host != (addr & r.mask)) return 1'b0;
      return (r.port == '0) || (carries_ports && port == r.port);
    endfunction

    // accepted request: update the table and queue the verdict
    function void note_request(request_t r);
      prr_pkg::res_t              v;
      logic [prr_pkg::ADDR_W-1:0] addr;
      logic [prr_pkg::PORT_W-1:0] port;
      v = '0;
      if (r.op == prr_pkg::OP_CHECK) begin
        addr = r.use_dst ? r.daddr : r.saddr;
        port = r.use_dst ? r.dport : r.sport;
        foreach (held_rules[k])
          if (rule_admits(held_rules[k], r.proto, addr, port)) v.matched = 1'b1;
      end else if (held_rules.size() >= prr_pkg::TABLE_DEPTH) begin
        v.status = prr_pkg::ST_FULL;
      end else begin
        foreach (held_rules[k])
          if (held_rules[k] == r.rule) v.status = prr_pkg::ST_DUP;
        if (v.status == prr_pkg::ST_OK) held_rules.push_back(r.rule);
      end
      v.count = prr_pkg::RCNT_W'(held_rules.size());
      verdict_q.push_back(v);
    endfunction

    // accepted result against the oldest verdict
    function void check_result(logic [prr_pkg::OUT_TDATA_W-1:0] d);
      prr_pkg::res_t want;
      if (verdict_q.size() == 0) begin
        $error("result with no request outstanding: tdata %h", d);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      if (d[0] !== want.matched) begin
        $error("matched: expected %0d, actual %0d", want.matched, d[0]);
        mismatches++;
      end
      if (d[2:1] !== want.status) begin
        $error("add_status: expected %0d, actual %0d", want.status, d[2:1]);
        mismatches++;
      end
      if (d[9:3] !== want.count) begin
        $error("rule_count: expected %0d, actual %0d", want.count, d[9:3]);
        mismatches++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [prr_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                            in_tuser  = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [prr_pkg::OUT_TDATA_W-1:0] out_tdata;

  int send_idle_pct = 6;
  int recv_idle_pct = 47;

  rule_table_tracker tracker;
  prr_pkg::rule_t    rule_pool[POOL_SIZE];

  packet_pass_rule_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // request with every field random
  function automatic request_t noise_request();
    request_t r;
    r.op         = 1'($urandom_range(1));
    r.use_dst    = 1'($urandom_range(1));
    r.proto      = prr_pkg::PROTO_W'($urandom);
    r.saddr      = $urandom;
    r.daddr      = $urandom;
    r.sport      = prr_pkg::PORT_W'($urandom);
    r.dport      = prr_pkg::PORT_W'($urandom);
    r.rule.proto = prr_pkg::PROTO_W'($urandom);
    r.rule.host  = $urandom;
    r.rule.mask  = $urandom;
    r.rule.port  = prr_pkg::PORT_W'($urandom);
    return r;
  endfunction

  function automatic request_t rule_request(prr_pkg::rule_t rule);
    request_t r;
    r      = noise_request();
    r.op   = prr_pkg::OP_ADD;
    r.rule = rule;
    return r;
  endfunction

  function automatic request_t packet_request(logic use_dst,
                                              logic [prr_pkg::PROTO_W-1:0] proto,
                                              logic [prr_pkg::ADDR_W-1:0] addr,
                                              logic [prr_pkg::PORT_W-1:0] port);
    request_t r;
    r         = noise_request();
    r.op      = prr_pkg::OP_CHECK;
    r.use_dst = use_dst;
    r.proto   = proto;
    if (use_dst) begin
      r.daddr = addr;
      r.dport = port;
    end else begin
      r.saddr = addr;
      r.sport = port;
    end
    return r;
  endfunction

  // rule shaped like real filters: prefix masks, wildcards, well-known protocols
  function automatic prr_pkg::rule_t random_rule();
    prr_pkg::rule_t r;
    int             plen;
    case ($urandom_range(3))
      0: r.proto = '0;
      1: r.proto = prr_pkg::PROTO_TCP;
      2: r.proto = prr_pkg::PROTO_UDP;
      default: r.proto = prr_pkg::PROTO_W'($urandom);
    endcase
    plen   = $urandom_range(32);
    r.mask = (plen == 0) ? '0 : ('1 << (32 - plen));
    if ($urandom_range(9) == 0) r.mask = $urandom;
    case ($urandom_range(4))
      0: r.host = '0;
      1: r.host = $urandom;
      default: r.host = $urandom & r.mask;
    endcase
    case ($urandom_range(4))
      0, 1: r.port = '0;
      2: r.port = '1;
      default: r.port = prr_pkg::PORT_W'($urandom);
    endcase
    return r;
  endfunction

  // packet built to pass a given rule, sometimes with one field spoiled
  function automatic request_t aimed_request(prr_pkg::rule_t rule);
    logic [prr_pkg::PROTO_W-1:0] proto;
    logic [prr_pkg::ADDR_W-1:0]  addr;
    logic [prr_pkg::PORT_W-1:0]  port;
    proto = rule.proto;
    if (proto == '0) begin
      case ($urandom_range(2))
        0: proto = prr_pkg::PROTO_TCP;
        1: proto = prr_pkg::PROTO_UDP;
        default: proto = prr_pkg::PROTO_W'($urandom);
      endcase
    end
    addr = (rule.host & rule.mask) | ($urandom & ~rule.mask);
    port = (rule.port != '0) ? rule.port : prr_pkg::PORT_W'($urandom);
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(2))
        0: proto = proto ^ (prr_pkg::PROTO_W'(1) << $urandom_range(prr_pkg::PROTO_W - 1));
        1: addr  = addr ^ (prr_pkg::ADDR_W'(1) << $urandom_range(prr_pkg::ADDR_W - 1));
        default: port = port ^ (prr_pkg::PORT_W'(1) << $urandom_range(prr_pkg::PORT_W - 1));
      endcase
    end
    return packet_request(1'($urandom_range(1)), proto, addr, port);
  endfunction

  // drive one request and wait for its handshake
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {7'b0, r.rule.port, r.rule.mask, r.rule.host, r.rule.proto,
                  r.dport, r.sport, r.daddr, r.saddr, r.proto, r.use_dst};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_request(r);
  endtask

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin
    prr_pkg::rule_t web;
    prr_pkg::rule_t dns;
    prr_pkg::rule_t icmp_any;
    prr_pkg::rule_t top_rule;
    prr_pkg::rule_t top_tcp;
    prr_pkg::rule_t no_mask;
    request_t       r;
    int             draw;

    tracker  = new();
    web      = '{proto: prr_pkg::PROTO_TCP, host: 32'h0a00_0000,
                 mask: 32'hff00_0000, port: 16'd80};
    dns      = '{proto: '0, host: 32'hc0a8_0101, mask: '1, port: 16'd53};
    icmp_any = '{proto: 8'd1, host: '0, mask: '0, port: '0};
    top_rule = '{proto: '1, host: '1, mask: '1, port: '1};
    top_tcp  = '{proto: prr_pkg::PROTO_TCP, host: '1, mask: '1, port: '1};
    no_mask  = '{proto: prr_pkg::PROTO_UDP, host: 32'h1234_5678, mask: '0, port: '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table with field extremes
    r    = '1;
    r.op = prr_pkg::OP_CHECK;
    send_request(r);
    r    = '0;
    send_request(r);

    // add, duplicate, then direction, protocol and port tests
    send_request(rule_request(web));
    send_request(rule_request(web));
    send_request(packet_request(1'b1, prr_pkg::PROTO_TCP, 32'h0a01_0203, 16'd80));
    send_request(packet_request(1'b0, prr_pkg::PROTO_TCP, 32'h0b01_0203, 16'd80));
    send_request(packet_request(1'b1, prr_pkg::PROTO_UDP, 32'h0a01_0203, 16'd80));
    send_request(packet_request(1'b1, prr_pkg::PROTO_TCP, 32'h0a01_0203, 16'd81));

    // any-protocol rule with a port: port only passes for tcp or udp
    send_request(rule_request(dns));
    send_request(packet_request(1'b0, prr_pkg::PROTO_UDP, 32'hc0a8_0101, 16'd53));
    send_request(packet_request(1'b0, 8'd1, 32'hc0a8_0101, 16'd53));

    // wildcard host and port
    send_request(rule_request(icmp_any));
    send_request(packet_request(1'b0, 8'd1, 32'hdead_beef, '0));

    // all-ones rules
    send_request(rule_request(top_rule));
    send_request(packet_request(1'b1, '1, '1, '1));
    send_request(rule_request(top_tcp));
    send_request(packet_request(1'b1, prr_pkg::PROTO_TCP, '1, '1));

    // host bits outside a zero mask never match
    send_request(rule_request(no_mask));
    send_request(packet_request(1'b0, prr_pkg::PROTO_UDP, 32'h1234_5678, '0));

    // random part: pool adds fill the table, checks aim at held or pool rules
    foreach (rule_pool[k]) rule_pool[k] = random_rule();
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 6;
      end else if (n == 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      draw = $urandom_range(99);
      if (draw < 12) begin
        r = rule_request(rule_pool[$urandom_range(POOL_SIZE - 1)]);
      end else if (draw < 14) begin
        r    = noise_request();
        r.op = prr_pkg::OP_ADD;
      end else if (draw < 72) begin
        if (tracker.held_rules.size() > 0 && $urandom_range(9) < 7)
          r = aimed_request(tracker.held_rules[$urandom_range(tracker.held_rules.size() - 1)]);
        else
          r = aimed_request(rule_pool[$urandom_range(POOL_SIZE - 1)]);
      end else begin
        r    = noise_request();
        r.op = prr_pkg::OP_CHECK;
      end
      send_request(r);
    end
    in_tvalid <= 1'b0;

    // drain, then allow for a late extra result
    while (tracker.pending() != 0) @(posedge clk);
    repeat (prr_pkg::TABLE_DEPTH + 8) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
